// ===== design/anhc_pkg.sv =====
// ----------------------------------------------------------------------------
// anhc_pkg: shared types and constants for the address name hash cache
// Beat structs, table entry layout, command codes, controller states and the
// address fold that produces the window base.
// ----------------------------------------------------------------------------
package anhc_pkg;

	localparam int unsigned ADDR_W           = 64;
	localparam int unsigned HANDLE_W         = 32;
	localparam int unsigned SLOT_W           = 17;
	localparam int unsigned HASH_STEP        = 3;
	localparam int unsigned HASH_TERMS       = (ADDR_W + HASH_STEP - 1) / HASH_STEP;
	localparam int unsigned HASH_BITS_DEF    = 16;
	localparam int unsigned WINDOW_SLOTS_DEF = 5;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [ADDR_W-1:0]   address;
		logic [ADDR_W-1:0]   end_address;
		logic [HANDLE_W-1:0] name_handle;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] found_handle;
		logic [SLOT_W-1:0]   slot_index;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   address;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// XOR of every copy of the address shifted right by a multiple of the step;
	// the caller keeps the low hash bits
	function automatic logic [ADDR_W-1:0] anhc_fold(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < HASH_TERMS; k++) begin
			acc = acc ^ (a >> (HASH_STEP * k));
		end
		return acc;
	endfunction

endpackage

// ===== design/address_name_hash_cache.sv =====
// ----------------------------------------------------------------------------
// address_name_hash_cache: 64-bit address to 32-bit name handle cache
// Hashed table with a probe window; lookup, insert and region removal.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/req_stall | req_t: cmd, address, end_address, name_handle
//   rsp     | out | rsp_valid/rsp_stall | rsp_t: hit, found_handle, slot_index
//
// Lookup makes one table read per window slot through the single read port;
// its steps are accept, table reads, compare and result push, and a hit ends it early.
// Insert and unused commands make no table read; removal reads every entry once.
// After reset the table is cleared one entry per cycle, all
// 2^HASH_BITS + WINDOW_SLOTS entries, while req_stall stays high.
// A result waits in the output register; a new request is taken meanwhile.
// ----------------------------------------------------------------------------
module address_name_hash_cache import anhc_pkg::*; #(
	parameter int unsigned HASH_BITS    = HASH_BITS_DEF,
	parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned SPAN  = (1 << HASH_BITS) + WINDOW_SLOTS;
	localparam int unsigned IDX_W = $clog2(SPAN);

	logic             res_push;
	rsp_t             res;
	logic             res_free;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	entry_t           mem_rd_data;
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	entry_t           mem_wr_data;

	anhc_ctrl #(
		.HASH_BITS   (HASH_BITS),
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.res_push   (res_push),
		.res        (res),
		.res_free   (res_free),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data)
	);

	anhc_mem #(
		.HASH_BITS   (HASH_BITS),
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_mem (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	// output register: free when empty or when its beat leaves this cycle
	assign res_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_push) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/anhc_mem.sv =====
// ----------------------------------------------------------------------------
// anhc_mem: entry table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module anhc_mem import anhc_pkg::*; #(
	parameter int unsigned HASH_BITS    = HASH_BITS_DEF,
	parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEF,
	localparam int unsigned SPAN        = (1 << HASH_BITS) + WINDOW_SLOTS,
	localparam int unsigned IDX_W       = $clog2(SPAN)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem_q [SPAN];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/anhc_ctrl.sv =====
// ----------------------------------------------------------------------------
// anhc_ctrl: command sequencer for the entry table
// Clears the table after reset, then runs lookups over the probe window,
// inserts at the window base and sweeps the table for region removal.
// ----------------------------------------------------------------------------
module anhc_ctrl import anhc_pkg::*; #(
	parameter int unsigned HASH_BITS    = HASH_BITS_DEF,
	parameter int unsigned WINDOW_SLOTS = WINDOW_SLOTS_DEF,
	localparam int unsigned SPAN        = (1 << HASH_BITS) + WINDOW_SLOTS,
	localparam int unsigned IDX_W       = $clog2(SPAN)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             res_push,
	output rsp_t             res,
	input  logic             res_free,
	output logic             mem_rd_en,
	output logic [IDX_W-1:0] mem_rd_addr,
	input  entry_t           mem_rd_data,
	output logic             mem_wr_en,
	output logic [IDX_W-1:0] mem_wr_addr,
	output entry_t           mem_wr_data
);

	localparam int unsigned KW       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SPAN - 1);
	localparam logic [KW-1:0]    LAST_K   = KW'(WINDOW_SLOTS - 1);

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q;
	logic [KW-1:0]      k_q;
	logic               issue_done_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  end_q;
	logic [IDX_W-1:0]   base_q;
	rsp_t               res_q, res_d;
	logic               load_res;
	logic               rvalid_s1;
	logic               rlast_s1;
	logic [IDX_W-1:0]   ridx_s1;
	logic               rd_last;
	logic               accept;
	logic [ADDR_W-1:0]  fold;
	logic [IDX_W-1:0]   base_in;
	logic               in_range;

	// window base of the incoming address
	assign fold    = anhc_fold(req.address);
	assign base_in = {{(IDX_W - HASH_BITS){1'b0}}, fold[HASH_BITS-1:0]};

	assign accept   = req_valid && !req_stall;
	assign in_range = (mem_rd_data.address >= addr_q) && (mem_rd_data.address <= end_q);
	assign res      = res_q;

	// next state, memory strobes and result load
	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		mem_rd_en   = 1'b0;
		mem_rd_addr = idx_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_q;
		mem_wr_data = '0;
		res_push    = 1'b0;
		load_res    = 1'b0;
		res_d       = '0;
		rd_last     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					unique case (req.cmd)
						CMD_LOOKUP: begin
							state_d = ST_LOOK;
						end
						CMD_INSERT: begin
							mem_wr_en                = 1'b1;
							mem_wr_addr              = base_in;
							mem_wr_data.address      = req.address;
							mem_wr_data.handle       = req.name_handle;
							load_res                 = 1'b1;
							res_d.hit                = 1'b1;
							res_d.found_handle       = req.name_handle;
							res_d.slot_index         = SLOT_W'(base_in);
							state_d                  = ST_DONE;
						end
						CMD_REMOVE: begin
							state_d = ST_SWEEP;
						end
						CMD_NONE: begin
							load_res = 1'b1;
							state_d  = ST_DONE;
						end
					endcase
				end
			end
			ST_LOOK: begin
				rd_last     = (k_q == LAST_K);
				mem_rd_addr = base_q + IDX_W'(k_q);
				mem_rd_en   = !issue_done_q;
				if (rvalid_s1 && (mem_rd_data.address == addr_q)) begin
					load_res           = 1'b1;
					res_d.hit          = 1'b1;
					res_d.found_handle = mem_rd_data.handle;
					res_d.slot_index   = SLOT_W'(ridx_s1);
					state_d            = ST_DONE;
				end else if (rvalid_s1 && rlast_s1) begin
					load_res = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_SWEEP: begin
				rd_last   = (idx_q == LAST_IDX);
				mem_rd_en = !issue_done_q;
				// write back a cleared entry one slot behind the read
				if (rvalid_s1 && in_range) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = ridx_s1;
				end
				if (rvalid_s1 && rlast_s1) begin
					load_res = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			idx_q        <= '0;
			k_q          <= '0;
			issue_done_q <= 1'b0;
			rvalid_s1    <= 1'b0;
			rlast_s1     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= mem_rd_en;
			rlast_s1  <= mem_rd_en && rd_last;
			if (accept) begin
				idx_q        <= '0;
				k_q          <= '0;
				issue_done_q <= 1'b0;
			end else if (state_q == ST_CLEAR) begin
				idx_q <= idx_q + 1'b1;
			end else if (mem_rd_en) begin
				idx_q <= idx_q + 1'b1;
				k_q   <= k_q + 1'b1;
				if (rd_last) begin
					issue_done_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ridx_s1 <= mem_rd_addr;
		if (accept) begin
			addr_q <= req.address;
			end_q  <= req.end_address;
			base_q <= base_in;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
		else $error("read and write hit the same entry in one cycle");

	a_sweep_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && mem_wr_en) |-> (mem_wr_addr == $past(mem_rd_addr)))
		else $error("sweep cleared an entry it did not just read");

	a_look_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK && rvalid_s1) |-> ((ridx_s1 - base_q) < IDX_W'(WINDOW_SLOTS)))
		else $error("lookup compared an entry outside its probe window");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !res_push)
		else $error("two results pushed back to back");

	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("second request taken before the first finished");

endmodule

// ===== bench/tb_address_name_hash_cache.sv =====
// ----------------------------------------------------------------------------
// tb_address_name_hash_cache: self-checking bench for the address name cache
// Drives lookup, insert, region removal and unused command beats, first from
// a directed table and then from random traffic built around a small pool of
// addresses and same-window aliases. A bench table model predicts each result
// not typed in a directed row; a monitor compares each beat field by field.
// ----------------------------------------------------------------------------
module tb_address_name_hash_cache;
	import anhc_pkg::*;

	localparam int unsigned TBL_SPAN   = (1 << HASH_BITS_DEF) + WINDOW_SLOTS_DEF;
	localparam int          RAND_BEATS = 830;
	localparam int          IDLE_LIMIT = 200000;
	localparam int          HOLD_LEN   = 300;
	localparam logic [63:0] ADDR_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// bench copy of the table
	bit [ADDR_W-1:0]   tbl_addr   [TBL_SPAN];
	bit [HANDLE_W-1:0] tbl_handle [TBL_SPAN];

	rsp_t     pending_rsp [$];
	dir_row_t dir_rows [$];
	logic [63:0] addr_pool [16];

	int  errors = 0;
	int  idle_cycles = 0;
	int  n_beats = 0, n_hits = 0, n_misses = 0, n_inserts = 0, n_removes = 0, n_unused = 0;
	bit  steady = 1'b0;
	bit  hold_rsp = 1'b0;
	bit  hold_done = 1'b0;
	rsp_t got_want;

	always #5 clk = ~clk;

	address_name_hash_cache #(
		.HASH_BITS    (HASH_BITS_DEF),
		.WINDOW_SLOTS (WINDOW_SLOTS_DEF)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// window base: XOR of the address and all its 3-bit right shifts, low hash bits
	function automatic logic [SLOT_W-1:0] window_of(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] acc;
		logic [ADDR_W-1:0] v;
		acc = '0;
		v = a;
		while (v != 0) begin
			acc = acc ^ v;
			v = v >> 3;
		end
		return SLOT_W'(acc[HASH_BITS_DEF-1:0]);
	endfunction

	// another address that lands on the same window base
	function automatic logic [63:0] alias_of(input logic [63:0] a);
		logic [63:0] y;
		y = {$urandom, $urandom} & 64'h1FFF_FFFF_FFFF_E000;
		if (y == 0)
			y = 64'h2000;
		return a ^ y ^ (y << 3);
	endfunction

	function automatic dir_row_t row_of(input cmd_t c, input logic [63:0] a,
			input logic [63:0] e, input logic [31:0] h, input bit t,
			input logic w_hit, input logic [31:0] w_handle, input logic [16:0] w_slot);
		dir_row_t r;
		r.beat = '{cmd: c, address: a, end_address: e, name_handle: h};
		r.typed = t;
		r.want = '{hit: w_hit, found_handle: w_handle, slot_index: w_slot};
		return r;
	endfunction

	// advance the table model by one beat and work out its result
	task automatic resolve_beat(input req_t b, output rsp_t r);
		logic [SLOT_W-1:0] base;
		int idx;
		r = '0;
		n_beats++;
		case (b.cmd)
			CMD_LOOKUP: begin
				base = window_of(b.address);
				for (int k = 0; k < WINDOW_SLOTS_DEF; k++) begin
					idx = int'(base) + k;
					if (!r.hit && tbl_addr[idx] == b.address) begin
						r.hit = 1'b1;
						r.found_handle = tbl_handle[idx];
						r.slot_index = SLOT_W'(idx);
					end
				end
				if (r.hit)
					n_hits++;
				else
					n_misses++;
			end
			CMD_INSERT: begin
				base = window_of(b.address);
				tbl_addr[base] = b.address;
				tbl_handle[base] = b.name_handle;
				r = '{hit: 1'b1, found_handle: b.name_handle, slot_index: base};
				n_inserts++;
			end
			CMD_REMOVE: begin
				for (int i = 0; i < TBL_SPAN; i++) begin
					if (tbl_addr[i] >= b.address && tbl_addr[i] <= b.end_address) begin
						tbl_addr[i] = '0;
						tbl_handle[i] = '0;
					end
				end
				n_removes++;
			end
			default: n_unused++;
		endcase
	endtask

	// offer one beat, hold it until taken, log its result, then idle or drain
	task automatic send_beat(input req_t b, input bit typed, input rsp_t typed_want,
			input bit drain);
		rsp_t want;
		int gap;
		req <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		resolve_beat(b, want);
		pending_rsp.push_back(typed ? typed_want : want);
		gap = 0;
		if (!steady)
			while ($urandom_range(0, 99) < 33)
				gap++;
		if (drain || gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && pending_rsp.size() != 0)
				@(posedge clk);
		end
	endtask

	// reset and table model clear
	initial begin
		for (int i = 0; i < TBL_SPAN; i++) begin
			tbl_addr[i] = '0;
			tbl_handle[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender
	initial begin : sender
		req_t b;
		logic [63:0] a, e;
		int p, j;
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h0, ADDR_MAX, 32'h0, 1, 1'b1, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, ADDR_MAX, 64'h0, ADDR_MAX[31:0], 1, 1'b0, 32'h0,
			17'd0));
		dir_rows.push_back(row_of(CMD_INSERT, 64'h1, ADDR_MAX, 32'hFFFF_FFFF, 1, 1'b1,
			32'hFFFF_FFFF, 17'd1));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h1, 64'h0, 32'h0, 1, 1'b1, 32'hFFFF_FFFF, 17'd1));
		dir_rows.push_back(row_of(CMD_INSERT, ADDR_MAX, 64'h0, 32'h0, 0, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, ADDR_MAX, ADDR_MAX, 32'h0, 0, 1'b0, 32'h0, 17'd0));
		// nonzero address whose window base is zero
		dir_rows.push_back(row_of(CMD_INSERT, 64'h1_2000, 64'h0, 32'hA5A5_A5A5, 1, 1'b1,
			32'hA5A5_A5A5, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h0, 64'h0, 32'h0, 0, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h1_2000, 64'h0, 32'h0, 1, 1'b1, 32'hA5A5_A5A5,
			17'd0));
		dir_rows.push_back(row_of(CMD_INSERT, 64'h8000_0000_0000_0000, 64'h0, 32'h5A5A_5A5A, 0,
			1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h8000_0000_0000_0000, 64'h0, 32'h0, 0, 1'b0,
			32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_NONE, ADDR_MAX, ADDR_MAX, 32'hFFFF_FFFF, 1, 1'b0, 32'h0,
			17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h1_2000, 64'h0, 32'h0, 0, 1'b0, 32'h0, 17'd0));
		// empty region: start above end
		dir_rows.push_back(row_of(CMD_REMOVE, ADDR_MAX, 64'h0, 32'h0, 1, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h1, 64'h0, 32'h0, 0, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_REMOVE, 64'h1, 64'h1, 32'h0, 1, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h1, 64'h0, 32'h0, 1, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h0, 64'h0, 32'h0, 0, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_REMOVE, 64'h0, ADDR_MAX, 32'h0, 1, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h1_2000, 64'h0, 32'h0, 1, 1'b0, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_LOOKUP, 64'h0, 64'h0, 32'h0, 1, 1'b1, 32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_INSERT, 64'hFFFF_FFFF, 64'h0, 32'h8000_0001, 0, 1'b0,
			32'h0, 17'd0));
		dir_rows.push_back(row_of(CMD_NONE, 64'h0, 64'h0, 32'h0, 1, 1'b0, 32'h0, 17'd0));

		// address pool: wide random, small, same-window aliases, random high half with small low bits
		for (int i = 0; i < 16; i++) begin
			case (i % 4)
				0: addr_pool[i] = {$urandom, $urandom};
				1: addr_pool[i] = 64'($urandom_range(0, 255));
				2: addr_pool[i] = alias_of(addr_pool[i-1]);
				default: addr_pool[i] = {$urandom, 32'h0} | 64'($urandom_range(0, 15));
			endcase
		end

		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want, 1'b0);

		for (int n = 0; n < RAND_BEATS; n++) begin
			steady = (n >= 250 && n < 400);
			// start the output hold-off away from any region removal
			if (n == 450)
				hold_rsp = 1'b1;
			j = $urandom_range(0, 15);
			b.end_address = {$urandom, $urandom};
			b.name_handle = $urandom;
			if (n % 200 == 100) begin
				// region removal: whole space, one pool address, random span, empty
				b.cmd = CMD_REMOVE;
				case ($urandom_range(0, 3))
					0: begin
						a = 64'h0;
						e = ADDR_MAX;
					end
					1: begin
						a = addr_pool[j];
						e = addr_pool[j];
					end
					2: begin
						a = {$urandom, $urandom};
						e = {$urandom, $urandom};
						if (a > e) begin
							a = a ^ e;
							e = a ^ e;
							a = a ^ e;
						end
					end
					default: begin
						e = {$urandom, $urandom} >> 1;
						a = e + 64'($urandom_range(1, 1000));
					end
				endcase
				b.address = a;
				b.end_address = e;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 40) begin
					b.cmd = CMD_LOOKUP;
					b.address = addr_pool[j];
				end else if (p < 65) begin
					b.cmd = CMD_INSERT;
					b.address = addr_pool[j];
				end else if (p < 75) begin
					// overwrite the window base with a colliding address
					b.cmd = CMD_INSERT;
					b.address = alias_of(addr_pool[j]);
					if ($urandom_range(0, 1))
						addr_pool[j] = b.address;
				end else if (p < 85) begin
					b.cmd = CMD_LOOKUP;
					b.address = (p < 78) ? 64'h0 : {$urandom, $urandom};
				end else if (p < 95) begin
					b.cmd = CMD_INSERT;
					b.address = {$urandom, $urandom};
				end else begin
					b.cmd = CMD_NONE;
					b.address = {$urandom, $urandom};
				end
			end
			send_beat(b, 1'b0, '0, (n == 650) || (n == RAND_BEATS - 1));
		end

		repeat (20) @(posedge clk);
		$display("Run covered %0d beats: %0d lookup hits, %0d misses, %0d inserts,",
			n_beats, n_hits, n_misses, n_inserts);
		$display("%0d region removals, %0d unused commands, a long output hold-off and a drain.",
			n_removes, n_unused);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, a quiet stretch and one long hold-off
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_rsp && !hold_done) begin
				rsp_stall <= 1'b1;
				hold_done = 1'b1;
				for (int k = 0; k < HOLD_LEN; k++)
					@(posedge clk);
			end else if (steady)
				rsp_stall <= 1'b0;
			else
				rsp_stall <= ($urandom_range(0, 99) < 33);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_rsp.size() == 0) begin
				$error("result beat with nothing expected: hit %0d handle %h slot %0d",
					rsp.hit, rsp.found_handle, rsp.slot_index);
				errors++;
			end else begin
				got_want = pending_rsp.pop_front();
				if (rsp.hit !== got_want.hit) begin
					$error("hit: expected %0d, got %0d", got_want.hit, rsp.hit);
					errors++;
				end
				if (rsp.found_handle !== got_want.found_handle) begin
					$error("found_handle: expected %h, got %h", got_want.found_handle,
						rsp.found_handle);
					errors++;
				end
				if (rsp.slot_index !== got_want.slot_index) begin
					$error("slot_index: expected %0d, got %0d", got_want.slot_index,
						rsp.slot_index);
					errors++;
				end
			end
		end
	end

	// watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) ||
				(rsp_valid === 1'b1 && rsp_stall === 1'b0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
design/anhc_pkg.sv
design/anhc_mem.sv
design/anhc_ctrl.sv
design/address_name_hash_cache.sv
bench/tb_address_name_hash_cache.sv
